// ----- src/mau_pkg.sv -----
`default_nettype none
package mau_pkg;
    localparam int unsigned W = 31;
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;

    typedef struct packed {
        logic [2:0]   command;
        logic [W-1:0] operand_a;
        logic [W-1:0] operand_b;
    } mau_in_t;

    typedef struct packed {
        logic [W-1:0] result;
        logic         status;
    } mau_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_POW_STEP,
        ST_EUC_DIV,
        ST_EUC_UPD,
        ST_DIV_FIN,
        ST_DONE
    } mau_state_t;
endpackage
`default_nettype wire

// ----- src/modular_arithmetic_unit.sv -----
// every command first reduces its operands by restoring divides (power keeps the raw exponent);
// divide then runs euclid steps, each a restoring divide plus a shift-and-add modular multiply;
// power does one or two shift-and-add multiplies per exponent bit
// one item at a time: busy is high from accept until the result strobe
// the result strobe lasts one cycle and cannot be stalled by the receiver
// asynchronous active-low reset sets modulus to 2147483647 and returns to idle
`default_nettype none
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [W-1:0] cfg_data,
    input  wire logic         start,
    input  wire mau_in_t      in_data,
    output logic              busy,
    output logic              done,
    output mau_out_t          out_data
);
    localparam int unsigned CW = $clog2(W + 1);

    mau_state_t state_reg, state_next;
    logic [W-1:0] mod_reg;
    logic [W-1:0] m_reg;
    logic [2:0]   cmd_reg;
    logic [W-1:0] a_reg, b_reg, rawb_reg;
    // restoring divide datapath, shared by operand reduction and euclid
    logic [W:0]   rem_reg;
    logic [W-1:0] quo_reg;
    logic [W-1:0] dvd_reg;
    logic [CW-1:0] cnt_reg;
    // multiply operands and accumulator
    logic [W-1:0] mx_reg, my_reg, acc_reg;
    logic [1:0]   mret_reg;   // where multiply returns
    // euclid
    logic [W-1:0] r0_reg, r1_reg, t0_reg, t1_reg;
    logic [W-1:0] e_reg, pacc_reg;
    logic [1:0]   dret_reg;   // what divide is reducing
    logic [W-1:0] res_reg;
    logic         st_reg;
    logic         done_reg;

    localparam logic [1:0] RET_MUL = 2'd0, RET_PACC = 2'd1, RET_PBASE = 2'd2, RET_EUC = 2'd3;
    localparam logic [1:0] DV_A = 2'd0, DV_B = 2'd1, DV_EUC = 2'd2;

    function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            addm = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
        end
    endfunction

    function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
        begin
            subm = (x >= y) ? x - y : x + (m - y);
        end
    endfunction

    assign done = done_reg;
    assign out_data.result = res_reg;
    assign out_data.status = st_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EUC_DIV;
            end
            ST_EUC_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    case (dret_reg)
                        DV_A:    state_next = ST_EUC_DIV;
                        DV_B:    state_next = ST_DISPATCH;
                        default: state_next = ST_MUL;
                    endcase
                end
            end
            ST_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_MUL: state_next = ST_MUL;
                    CMD_DIV: state_next = ST_EUC_UPD;
                    CMD_POW: state_next = ST_POW_STEP;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_EUC_UPD:
            begin
                if (r1_reg != '0)
                    state_next = ST_EUC_DIV;
                else
                    state_next = ST_DIV_FIN;
            end
            ST_DIV_FIN:
            begin
                if (r0_reg != W'(1))
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_POW_STEP:
            begin
                if (e_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (my_reg == '0)
                begin
                    case (mret_reg)
                        RET_MUL:   state_next = ST_DONE;
                        RET_PACC:  state_next = ST_MUL;
                        RET_PBASE: state_next = ST_POW_STEP;
                        default:   state_next = ST_EUC_UPD;
                    endcase
                end
            end
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != ST_IDLE);
    end

    // divide step: rem/quo shift in dividend bits msb first
    logic [W:0] rsh;
    always_comb
    begin
        rsh = {rem_reg[W-1:0], dvd_reg[W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mod_reg   <= W'(2147483647);
            done_reg  <= 1'b0;
            res_reg   <= '0;
            st_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            if (cfg_we)
                mod_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        m_reg    <= (mod_reg == '0) ? W'(1) : mod_reg;
                        cmd_reg  <= in_data.command;
                        rawb_reg <= in_data.operand_b;
                        b_reg    <= in_data.operand_b;
                        dvd_reg  <= in_data.operand_a;
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(W);
                        dret_reg <= DV_A;
                    end
                end
                ST_EUC_DIV:
                begin
                    // restoring divide of dvd by divisor
                    if (cnt_reg != '0)
                    begin
                        if (rsh >= {1'b0, (dret_reg == DV_EUC) ? r1_reg : m_reg})
                        begin
                            rem_reg <= rsh - {1'b0, (dret_reg == DV_EUC) ? r1_reg : m_reg};
                            quo_reg <= {quo_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rsh;
                            quo_reg <= {quo_reg[W-2:0], 1'b0};
                        end
                        dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        case (dret_reg)
                            DV_A:
                            begin
                                a_reg    <= rem_reg[W-1:0];
                                dvd_reg  <= b_reg;
                                rem_reg  <= '0;
                                cnt_reg  <= CW'(W);
                                dret_reg <= DV_B;
                            end
                            DV_B:
                            begin
                                b_reg <= rem_reg[W-1:0];
                            end
                            default:
                            begin
                                // q in quo, r2 in rem
                                // q <= r0/r1 <= m, so q mod m is one compare
                                mx_reg   <= (quo_reg >= m_reg) ? quo_reg - m_reg : quo_reg;
                                my_reg   <= t1_reg;
                                acc_reg  <= '0;
                                r0_reg   <= r1_reg;
                                r1_reg   <= rem_reg[W-1:0];
                                mret_reg <= RET_EUC;
                            end
                        endcase
                    end
                end
                ST_DISPATCH:
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            res_reg <= addm(a_reg, b_reg, m_reg);
                            st_reg  <= 1'b0;
                        end
                        CMD_SUB:
                        begin
                            res_reg <= subm(a_reg, b_reg, m_reg);
                            st_reg  <= 1'b0;
                        end
                        CMD_MUL:
                        begin
                            mx_reg <= a_reg;
                            my_reg <= b_reg;
                            acc_reg <= '0;
                            mret_reg <= RET_MUL;
                        end
                        CMD_DIV:
                        begin
                            r0_reg <= m_reg;
                            r1_reg <= b_reg;
                            t0_reg <= '0;
                            t1_reg <= (m_reg == W'(1)) ? '0 : W'(1);
                        end
                        CMD_POW:
                        begin
                            e_reg    <= rawb_reg;
                            pacc_reg <= (m_reg == W'(1)) ? '0 : W'(1);
                        end
                        default:
                        begin
                            res_reg <= '0;
                            st_reg  <= 1'b0;
                        end
                    endcase
                end
                ST_EUC_UPD:
                begin
                    // loop head of euclid
                    if (r1_reg != '0)
                    begin
                        dvd_reg  <= r0_reg;
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(W);
                        dret_reg <= DV_EUC;
                    end
                end
                ST_DIV_FIN:
                begin
                    if (r0_reg != W'(1))
                    begin
                        res_reg <= '0;
                        st_reg  <= 1'b1;
                    end
                    else
                    begin
                        mx_reg  <= a_reg;
                        my_reg  <= t0_reg;
                        acc_reg <= '0;
                        mret_reg <= RET_MUL;
                    end
                end
                ST_POW_STEP:
                begin
                    if (e_reg == '0)
                    begin
                        res_reg <= pacc_reg;
                        st_reg  <= 1'b0;
                    end
                    else if (e_reg[0])
                    begin
                        mx_reg  <= pacc_reg;
                        my_reg  <= a_reg;
                        acc_reg <= '0;
                        mret_reg <= RET_PACC;
                    end
                    else
                    begin
                        mx_reg  <= a_reg;
                        my_reg  <= a_reg;
                        acc_reg <= '0;
                        mret_reg <= RET_PBASE;
                    end
                end
                ST_MUL:
                begin
                    // shift-and-add modular multiply, one multiplier bit a cycle
                    if (my_reg != '0)
                    begin
                        if (my_reg[0])
                            acc_reg <= addm(acc_reg, mx_reg, m_reg);
                        mx_reg <= addm(mx_reg, mx_reg, m_reg);
                        my_reg <= my_reg >> 1;
                    end
                    else
                    begin
                        case (mret_reg)
                            RET_MUL:
                            begin
                                res_reg <= acc_reg;
                                st_reg  <= 1'b0;
                            end
                            RET_PACC:
                            begin
                                pacc_reg <= acc_reg;
                                mx_reg   <= a_reg;
                                my_reg   <= a_reg;
                                acc_reg  <= '0;
                                mret_reg <= RET_PBASE;
                            end
                            RET_PBASE:
                            begin
                                a_reg <= acc_reg;
                                e_reg <= e_reg >> 1;
                            end
                            default:
                            begin
                                t0_reg <= t1_reg;
                                t1_reg <= subm(t0_reg, acc_reg, m_reg);
                            end
                        endcase
                    end
                end
                ST_DONE:
                begin
                    done_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- verif/modular_arithmetic_unit_test.sv -----
`timescale 1ns / 100ps
module modular_arithmetic_unit_test;
    import mau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [W-1:0] MAX_VAL = {W{1'b1}};
    localparam logic [W-1:0] RESET_MOD = 31'd2147483647;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [W-1:0] cfg_data = '0;
    logic         start = 1'b0;
    mau_in_t      in_data = '0;
    logic         busy;
    logic         done;
    mau_out_t     out_data;

    mau_in_t      pending_cmds[$];
    mau_out_t     expected_residues[$];
    logic [W-1:0] modulus_model = RESET_MOD;
    int           beats_sent = 0;
    int           beats_taken = 0;
    int           gap_left = 0;
    bit           no_gaps = 1'b0;
    int           mismatches = 0;
    int           results_checked = 0;
    int           not_invertible = 0;
    int           moduli_used = 1;
    int           idle_cycles = 0;

    modular_arithmetic_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .in_data  (in_data),
        .busy     (busy),
        .done     (done),
        .out_data (out_data)
    );

    always #4 clk = ~clk;

    function automatic mau_out_t predict_residue(mau_in_t cmd, logic [W-1:0] modr);
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned e;
        longint unsigned acc;
        longint unsigned base;
        longint signed   r0;
        longint signed   r1;
        longint signed   t0;
        longint signed   t1;
        longint signed   q;
        longint signed   tmp;
        mau_out_t        o;
        m = (modr == '0) ? 64'd1 : 64'(modr);
        a = 64'(cmd.operand_a) % m;
        b = 64'(cmd.operand_b) % m;
        acc = 0;
        o = '0;
        case (cmd.command)
            CMD_ADD: acc = (a + b) % m;
            CMD_SUB: acc = (a + m - b) % m;
            CMD_MUL: acc = (a * b) % m;
            CMD_DIV:
            begin
                r0 = longint'(m);
                r1 = longint'(b);
                t0 = 0;
                t1 = 1;
                while (r1 != 0)
                begin
                    q = r0 / r1;
                    tmp = r0 - q * r1;
                    r0 = r1;
                    r1 = tmp;
                    tmp = t0 - q * t1;
                    t0 = t1;
                    t1 = tmp;
                end
                if (r0 == 1)
                begin
                    t0 = ((t0 % longint'(m)) + longint'(m)) % longint'(m);
                    acc = (a * longint'(t0)) % m;
                end
                else
                    o.status = 1'b1;
            end
            CMD_POW:
            begin
                acc = 1 % m;
                base = a;
                e = 64'(cmd.operand_b);
                while (e != 0)
                begin
                    if (e[0])
                        acc = (acc * base) % m;
                    base = (base * base) % m;
                    e = e >> 1;
                end
            end
            default: acc = 0;
        endcase
        o.result = acc[W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
    endtask

    // driver: start is held until the beat is taken, then a drawn gap
    always @(negedge clk)
    begin
        if (start && beats_taken != beats_sent)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (rst_n && pending_cmds.size() > 0)
        begin
            in_data <= pending_cmds.pop_front();
            start <= 1'b1;
            beats_sent++;
            gap_left = no_gaps ? 0 : $urandom_range(0, 12);
        end
        else
            start <= 1'b0;
    end

    // monitor: the strobe belongs to the older item, so check before pushing
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_residues.size() == 0)
                    report_mismatch("strobe with nothing outstanding", 1, 0);
                else
                begin
                    mau_out_t want;
                    want = expected_residues.pop_front();
                    if (out_data.result !== want.result)
                        report_mismatch("result", out_data.result, want.result);
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (want.status)
                        not_invertible++;
                    results_checked++;
                end
            end
            if (start && !busy)
            begin
                expected_residues.push_back(predict_residue(in_data, modulus_model));
                beats_taken <= beats_taken + 1;
            end
            if (cfg_we)
                modulus_model <= cfg_data;
            idle_cycles = (done || (start && !busy)) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         expected_residues.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [W-1:0] pick_operand(logic [W-1:0] modr);
        case ($urandom_range(0, 5))
            0: return W'($urandom_range(0, 16));
            1: return MAX_VAL - W'($urandom_range(0, 3));
            2: return (modr > 2) ? modr - W'($urandom_range(1, 2)) : modr;
            3: return modr + W'($urandom_range(0, 2));
            default: return W'($urandom());
        endcase
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() > 0 || start || expected_residues.size() > 0 || busy);
    endtask

    task automatic write_modulus(logic [W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        moduli_used++;
    endtask

    task automatic queue_cmd(logic [2:0] op, logic [W-1:0] a, logic [W-1:0] b);
        mau_in_t c;
        c.command = op;
        c.operand_a = a;
        c.operand_b = b;
        pending_cmds.push_back(c);
    endtask

    initial
    begin
        logic [W-1:0] moduli[9];
        logic [W-1:0] exponent;
        logic [2:0]   op;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats on the reset modulus (prime)
        queue_cmd(CMD_ADD, MAX_VAL, MAX_VAL);
        queue_cmd(CMD_ADD, RESET_MOD - 1, 31'd1);
        queue_cmd(CMD_SUB, 31'd0, 31'd1);
        queue_cmd(CMD_SUB, MAX_VAL, 31'd5);
        queue_cmd(CMD_MUL, RESET_MOD - 1, RESET_MOD - 1);
        queue_cmd(CMD_MUL, 31'd0, MAX_VAL);
        queue_cmd(CMD_DIV, 31'd7, 31'd0);
        queue_cmd(CMD_DIV, 31'd7, RESET_MOD);
        queue_cmd(CMD_DIV, 31'd1, 31'd2);
        queue_cmd(CMD_DIV, MAX_VAL, RESET_MOD - 1);
        queue_cmd(CMD_POW, 31'd0, 31'd0);
        queue_cmd(CMD_POW, 31'd5, 31'd0);
        queue_cmd(CMD_POW, 31'd0, 31'd9);
        queue_cmd(CMD_POW, 31'd3, MAX_VAL);
        queue_cmd(CMD_POW, RESET_MOD - 1, MAX_VAL - 1);
        queue_cmd(3'd5, MAX_VAL, MAX_VAL);
        queue_cmd(3'd6, 31'd1, 31'd1);
        queue_cmd(3'd7, 31'd0, 31'd0);
        wait_idle();

        moduli[0] = 31'd1;
        moduli[1] = 31'd0;
        moduli[2] = 31'd2;
        moduli[3] = 31'd13;
        moduli[4] = 31'd12;
        moduli[5] = 31'h4000_0000;
        moduli[6] = W'($urandom());
        moduli[7] = W'($urandom_range(3, 1000));
        moduli[8] = MAX_VAL;
        foreach (moduli[i])
        begin
            write_modulus(moduli[i]);
            // a zero-gap stretch on every other setting
            no_gaps = i[0];
            for (int n = 0; n < 28; n++)
            begin
                op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
                // most exponents short, a few full width
                exponent = ($urandom_range(0, 3) == 0) ? W'($urandom())
                                                       : W'($urandom_range(0, 300));
                queue_cmd(op, pick_operand(moduli[i]),
                          (op == CMD_POW) ? exponent : pick_operand(moduli[i]));
            end
        end
        wait_idle();
        repeat (100) @(negedge clk);

        $display("checked %0d results over %0d modulus settings, %0d non-invertible divides",
                 results_checked, moduli_used, not_invertible);
        if (mismatches == 0 && expected_residues.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/mau_pkg.sv
src/modular_arithmetic_unit.sv
verif/modular_arithmetic_unit_test.sv
